// ----- rtl/idw_pkg.sv -----
// Shared types and constants of the inverse distance weights unit.
`timescale 1ns / 1ps
package idw_pkg;

   localparam int POS_W    = 24;
   localparam int VID_W    = 20;
   localparam int SRC_W    = 12;
   localparam int WGT_W    = 16;
   localparam int THR_W    = 16;
   localparam int POW_W    = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   // divider widths
   localparam int DEN_W  = 54;
   localparam int LOW_W  = 48;
   localparam int DCNT_W = 6;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER     = 4'd1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd3000;
   localparam logic [POW_W-1:0] POWER_RESET     = 2'd3;

   typedef struct packed {
      logic [1:0]              cmd;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [VID_W-1:0]        vertex_id;
   } req_payload_type;

   typedef struct packed {
      logic [VID_W-1:0] row_id;
      logic [SRC_W-1:0] source_id;
      logic [WGT_W-1:0] weight;
      logic             hit;
      logic             overflow;
      logic             last;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic              start;
      logic [DEN_W-1:0]  rem0;
      logic [LOW_W-1:0]  low;
      logic [DCNT_W-1:0] count;
      logic [DEN_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [LOW_W-1:0] quot;
   } div_rsp_type;

endpackage

// ----- rtl/idw_if.sv -----
// Valid/ready channel interfaces of the inverse distance weights unit.
`timescale 1ns / 1ps
interface idw_req_if;
   import idw_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface idw_rsp_if;
   import idw_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface idw_csr_if;
   import idw_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/idw_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module idw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  idw_pkg::div_req_type div_req,
   output idw_pkg::div_rsp_type div_rsp
);
   import idw_pkg::*;

   logic              busy_ff, done_ff;
   logic [DEN_W-1:0]  rem_ff, den_ff;
   logic [LOW_W-1:0]  low_ff, quot_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DEN_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, low_ff[LOW_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DCNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= div_req.rem0;
         low_ff  <= div_req.low;
         den_ff  <= div_req.den;
         cnt_ff  <= div_req.count;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         low_ff  <= {low_ff[LOW_W-2:0], 1'b0};
         quot_ff <= {quot_ff[LOW_W-2:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ----- rtl/inverse_distance_weights_unit.sv -----
// Top level of the inverse distance weights unit: source store, scan sequencer, results.
`timescale 1ns / 1ps
// Builds one row of an inverse-distance smoothing operator. Load sources with append
// items (clear empties the store); a query item scans every stored source once and
// returns one result per hit in load order, weights normalized to Q0.16, last set on
// the final one, or a single result with hit low when nothing is in range. A query
// holds the input channel for its whole run: a setup step squares the threshold, each
// stored source takes one store read and three squarings on the shared multiplier, and
// each hit takes a 16-step square root, the power products and a 48-step divider for
// 2^47/d^p. A normal row then reads the hit buffer and runs a 16-step divider for
// normalization per result; a row with coincident hits or a zero sum runs the divider
// once and then reads the hit buffer per result. The result side may stall each
// result. Config writes are taken in any cycle.
module inverse_distance_weights_unit #(
   parameter int MAX_SOURCES = 4096,
   parameter int MAX_HITS    = 64
) (
   input  logic       clock,
   input  logic       reset,
   idw_req_if.sink    req_ch,
   idw_rsp_if.source  rsp_ch,
   idw_csr_if.sink    csr_ch
);
   import idw_pkg::*;

   localparam int AW  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CW  = $clog2(MAX_SOURCES + 1);
   localparam int HW  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int HCW = $clog2(MAX_HITS + 1);
   localparam int HB_W = SRC_W + LOW_W + 1;

   localparam logic [4:0] S_IDLE  = 5'd0,  S_THR   = 5'd1,  S_THR2  = 5'd2,
                          S_RD    = 5'd3,  S_MX    = 5'd4,  S_MY    = 5'd5,
                          S_MZ    = 5'd6,  S_SUM   = 5'd7,  S_TEST  = 5'd8,
                          S_SQRT  = 5'd9,  S_RND   = 5'd10, S_POW   = 5'd11,
                          S_POW2  = 5'd12, S_RAW   = 5'd13, S_RAW_W = 5'd14,
                          S_NEXT  = 5'd15, S_PREP  = 5'd16, S_SHR_W = 5'd17,
                          S_HRD   = 5'd18, S_HSEL  = 5'd19, S_NRM_W = 5'd20,
                          S_OUT   = 5'd21;

   localparam logic [1:0] MODE_COINC = 2'd0, MODE_EQUAL = 2'd1, MODE_NORM = 2'd2;

   // control registers
   logic [4:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [THR_W-1:0] thr_ff;
   logic [POW_W-1:0] pow_ff;
   logic [HCW-1:0]   nhits_ff, nhits_in, ncoinc_ff, ncoinc_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [CW-1:0]           idx_ff, idx_in;
   logic [31:0]             thr2_ff, thr2_in;
   logic [50:0]             acc_ff, acc_in, s_ff, s_in;
   logic [31:0]             sq_rem_ff, sq_rem_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [16:0]             r_ff, r_in;
   logic [48:0]             dp_ff, dp_in;
   logic [1:0]              pcnt_ff, pcnt_in;
   logic [DEN_W-1:0]        sum_ff, sum_in;
   logic                    ovf_ff, ovf_in;
   logic [1:0]              mode_ff, mode_in;
   logic [WGT_W-1:0]        share_ff, share_in;
   logic [HCW-1:0]          hi_ff, hi_in;
   logic signed [POS_W-1:0] vx_ff, vy_ff, vz_ff;
   logic [VID_W-1:0]        vid_ff;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   // memories
   logic [3*POS_W-1:0] src_mem [MAX_SOURCES];
   logic [3*POS_W-1:0] src_rd_ff;
   logic [HB_W-1:0]    hb_mem [MAX_HITS];
   logic [HB_W-1:0]    hb_rd_ff;
   logic               hb_we;
   logic [HB_W-1:0]    hb_wdata;

   // shared multiplier
   logic [32:0] mul_a;
   logic [24:0] mul_b;
   logic [57:0] prod_c, prod_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                    req_fire, append_we, csr_fire;
   logic signed [POS_W-1:0] sel_src, sel_vtx;
   logic signed [POS_W:0]   diff;
   logic [POS_W:0]          adiff;
   logic [32:0]             sq_try;
   logic                    sq_ge;
   logic [16:0]             r_c;
   logic [1:0]              p_eff;
   logic [63:0]             nrm_num;
   logic [31:0]             idx_ext;
   logic [SRC_W-1:0]        hb_src;
   logic [LOW_W-1:0]        hb_raw;
   logic                    hb_coinc;
   logic                    hb_last;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign append_we = req_fire && req_ch.data.cmd == CMD_APPEND && count_ff < CW'(MAX_SOURCES);

   // source store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (append_we) begin
         src_mem[count_ff[AW-1:0]] <= {req_ch.data.pos_x, req_ch.data.pos_y, req_ch.data.pos_z};
      end
      src_rd_ff <= src_mem[idx_ff[AW-1:0]];
   end

   // hit buffer
   always_ff @(posedge clock) begin
      if (hb_we) begin
         hb_mem[nhits_ff[HW-1:0]] <= hb_wdata;
      end
      hb_rd_ff <= hb_mem[hi_ff[HW-1:0]];
   end
   assign {hb_src, hb_raw, hb_coinc} = hb_rd_ff;
   assign idx_ext  = 32'(idx_ff);
   assign hb_wdata = {idx_ext[SRC_W-1:0], div_rsp.quot, (s_ff == '0)};
   assign hb_last  = (hi_ff + 1'b1) == nhits_ff;

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         S_MY:    begin sel_src = src_rd_ff[POS_W +: POS_W]; sel_vtx = vy_ff; end
         S_MZ:    begin sel_src = src_rd_ff[0 +: POS_W];     sel_vtx = vz_ff; end
         default: begin sel_src = src_rd_ff[2*POS_W +: POS_W]; sel_vtx = vx_ff; end
      endcase
   end
   assign diff  = {sel_src[POS_W-1], sel_src} - {sel_vtx[POS_W-1], sel_vtx};
   assign adiff = diff[POS_W] ? (POS_W+1)'(-diff) : diff;

   always_comb begin
      case (state_ff)
         S_THR:   begin mul_a = 33'(thr_ff);        mul_b = 25'(thr_ff); end
         S_POW:   begin mul_a = dp_ff[32:0];        mul_b = 25'(r_ff);   end
         default: begin mul_a = 33'(adiff);         mul_b = adiff;       end
      endcase
   end
   assign prod_c = {25'b0, mul_a} * {33'b0, mul_b};
   always_ff @(posedge clock) prod_ff <= prod_c;

   // square root step and rounding
   assign sq_try = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign sq_ge  = {1'b0, sq_rem_ff} >= sq_try;
   assign r_c    = 17'(sq_res_ff) + ((sq_rem_ff > sq_res_ff) ? 17'd1 : 17'd0);
   assign p_eff  = (pow_ff == 2'd0) ? 2'd1 : pow_ff;
   // raw * 65535 as a shift and subtract
   assign nrm_num = {hb_raw, 16'b0} - 64'(hb_raw);

   idw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      nhits_in     = nhits_ff;
      ncoinc_in    = ncoinc_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      thr2_in      = thr2_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      sq_rem_in    = sq_rem_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      r_in         = r_ff;
      dp_in        = dp_ff;
      pcnt_in      = pcnt_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      mode_in      = mode_ff;
      share_in     = share_ff;
      hi_in        = hi_ff;
      rsp_data_in  = rsp_data_ff;
      hb_we        = 1'b0;
      div_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_ch.data.cmd)
                  CMD_CLEAR:  count_in = '0;
                  CMD_APPEND: if (append_we) count_in = count_ff + 1'b1;
                  CMD_QUERY: begin
                     nhits_in  = '0;
                     ncoinc_in = '0;
                     sum_in    = '0;
                     ovf_in    = 1'b0;
                     idx_in    = '0;
                     state_in  = S_THR;
                  end
                  default: ;
               endcase
            end
         end
         S_THR: state_in = S_THR2;
         S_THR2: begin
            thr2_in  = prod_ff[31:0];
            state_in = (count_ff == '0) ? S_PREP : S_RD;
         end
         S_RD: state_in = S_MX;
         S_MX: state_in = S_MY;
         S_MY: begin
            acc_in   = 51'(prod_ff);
            state_in = S_MZ;
         end
         S_MZ: begin
            acc_in   = acc_ff + 51'(prod_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            s_in     = acc_ff + 51'(prod_ff);
            state_in = S_TEST;
         end
         S_TEST: begin
            if (s_ff > 51'(thr2_ff)) begin
               state_in = S_NEXT;
            end else if (nhits_ff == HCW'(MAX_HITS)) begin
               // drop the hit, flag the row
               ovf_in   = 1'b1;
               state_in = S_NEXT;
            end else begin
               sq_rem_in = s_ff[31:0];
               sq_res_in = '0;
               sq_bit_in = 32'h4000_0000;
               state_in  = S_SQRT;
            end
         end
         S_SQRT: begin
            sq_rem_in = sq_ge ? sq_rem_ff - sq_try[31:0] : sq_rem_ff;
            sq_res_in = sq_ge ? (sq_res_ff >> 1) + sq_bit_ff : sq_res_ff >> 1;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff == 32'd1) state_in = S_RND;
         end
         S_RND: begin
            // round half up, never below one
            r_in     = (r_c == '0) ? 17'd1 : r_c;
            dp_in    = (r_c == '0) ? 49'd1 : 49'(r_c);
            pcnt_in  = p_eff - 2'd1;
            state_in = (p_eff == 2'd1) ? S_RAW : S_POW;
         end
         S_POW: state_in = S_POW2;
         S_POW2: begin
            dp_in    = prod_ff[48:0];
            pcnt_in  = pcnt_ff - 2'd1;
            state_in = (pcnt_ff == 2'd1) ? S_RAW : S_POW;
         end
         S_RAW: begin
            div_req.start = 1'b1;
            div_req.rem0  = '0;
            div_req.low   = {1'b1, {(LOW_W-1){1'b0}}};
            div_req.count = DCNT_W'(LOW_W);
            div_req.den   = DEN_W'(dp_ff);
            state_in      = S_RAW_W;
         end
         S_RAW_W: begin
            if (div_rsp.done) begin
               hb_we     = 1'b1;
               sum_in    = sum_ff + DEN_W'(div_rsp.quot);
               nhits_in  = nhits_ff + 1'b1;
               if (s_ff == '0) ncoinc_in = ncoinc_ff + 1'b1;
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            idx_in   = idx_ff + 1'b1;
            state_in = ((idx_ff + 1'b1) == count_ff) ? S_PREP : S_RD;
         end
         S_PREP: begin
            hi_in = '0;
            if (nhits_ff == '0) begin
               rsp_data_in = '{row_id: vid_ff, source_id: '0, weight: '0,
                               hit: 1'b0, overflow: 1'b0, last: 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end else if (ncoinc_ff != '0 || sum_ff == '0) begin
               // equal shares among coincident hits, or among all hits
               mode_in       = (ncoinc_ff != '0) ? MODE_COINC : MODE_EQUAL;
               div_req.start = 1'b1;
               div_req.rem0  = '0;
               div_req.low   = {16'hFFFF, {(LOW_W-16){1'b0}}};
               div_req.count = DCNT_W'(WGT_W);
               div_req.den   = DEN_W'((ncoinc_ff != '0) ? ncoinc_ff : nhits_ff);
               state_in      = S_SHR_W;
            end else begin
               mode_in  = MODE_NORM;
               state_in = S_HRD;
            end
         end
         S_SHR_W: begin
            if (div_rsp.done) begin
               share_in = div_rsp.quot[WGT_W-1:0];
               state_in = S_HRD;
            end
         end
         S_HRD: state_in = S_HSEL;
         S_HSEL: begin
            rsp_data_in = '{row_id: vid_ff, source_id: hb_src, weight: '0,
                            hit: 1'b1, overflow: ovf_ff, last: hb_last};
            if (mode_ff == MODE_NORM) begin
               // quotient fits 16 bits since raw never exceeds the row sum
               div_req.start = 1'b1;
               div_req.rem0  = DEN_W'(nrm_num[63:16]);
               div_req.low   = {nrm_num[15:0], {(LOW_W-16){1'b0}}};
               div_req.count = DCNT_W'(WGT_W);
               div_req.den   = sum_ff;
               state_in      = S_NRM_W;
            end else begin
               rsp_data_in.weight = (mode_ff == MODE_EQUAL || hb_coinc) ? share_ff : '0;
               rsp_valid_in       = 1'b1;
               state_in           = S_OUT;
            end
         end
         S_NRM_W: begin
            if (div_rsp.done) begin
               rsp_data_in.weight = div_rsp.quot[WGT_W-1:0];
               rsp_valid_in       = 1'b1;
               state_in           = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               hi_in        = hi_ff + 1'b1;
               state_in     = rsp_data_ff.last ? S_IDLE : S_HRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         nhits_ff     <= '0;
         ncoinc_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THRESHOLD_RESET;
         pow_ff       <= POWER_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         nhits_ff     <= nhits_in;
         ncoinc_ff    <= ncoinc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_fire && csr_ch.data.index == CSR_THRESHOLD) thr_ff <= csr_ch.data.data;
         if (csr_fire && csr_ch.data.index == CSR_POWER)     pow_ff <= csr_ch.data.data[1:0];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      thr2_ff     <= thr2_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      sq_rem_ff   <= sq_rem_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      r_ff        <= r_in;
      dp_ff       <= dp_in;
      pcnt_ff     <= pcnt_in;
      sum_ff      <= sum_in;
      ovf_ff      <= ovf_in;
      mode_ff     <= mode_in;
      share_ff    <= share_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
      if (req_fire && req_ch.data.cmd == CMD_QUERY) begin
         vx_ff  <= req_ch.data.pos_x;
         vy_ff  <= req_ch.data.pos_y;
         vz_ff  <= req_ch.data.pos_z;
         vid_ff <= req_ch.data.vertex_id;
      end
   end

   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      nhits_ff <= HCW'(MAX_HITS)) else $error("hit count past buffer depth");

   a_coinc_bound: assert property (@(posedge clock) disable iff (reset)
      ncoinc_ff <= nhits_ff) else $error("more coincident hits than hits");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SOURCES)) else $error("source count past store depth");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_RAW_W || state_ff == S_SHR_W || state_ff == S_NRM_W))
      else $error("divider finished with no one waiting");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.data.last |=> state_ff == S_IDLE)
      else $error("not idle after final item of a query");

endmodule

// ----- tb/sv/idw_checker.sv -----
// Checker for the inverse distance weights unit: predicts every row and compares results.
`timescale 1ns / 1ps
module idw_checker
   import idw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   idw_req_if        req_ch,
   idw_rsp_if        rsp_ch,
   idw_csr_if        csr_ch,
   output int        fail_count,
   output int        rows_pending
);

   localparam int STORE_DEPTH = 4096;
   localparam int HIT_LIMIT   = 64;

   logic signed [POS_W-1:0] store_x [STORE_DEPTH];
   logic signed [POS_W-1:0] store_y [STORE_DEPTH];
   logic signed [POS_W-1:0] store_z [STORE_DEPTH];
   int                      stored;
   logic [THR_W-1:0]        threshold;
   logic [POW_W-1:0]        power;
   rsp_payload_type         expected_weights [$];

   assign rows_pending = expected_weights.size();

   task automatic report_mismatch(string what);
      $display("ERROR %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic longint unsigned square_gap(logic signed [POS_W-1:0] a,
                                                  logic signed [POS_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return longint'(d * d);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Scan the store for one query and queue the row it should produce.
   task automatic predict_row(req_payload_type q);
      longint unsigned thr2, s, r, dp, sum, w;
      longint unsigned raw [$];
      int              src [$];
      bit              coinc [$];
      int              ncoinc, n, p;
      bit              ovf;
      rsp_payload_type o;
      thr2   = longint'(threshold) * longint'(threshold);
      p      = (power == 0) ? 1 : int'(power);
      sum    = 0;
      ncoinc = 0;
      ovf    = 0;
      for (int i = 0; i < stored; i++) begin
         s = square_gap(store_x[i], q.pos_x) + square_gap(store_y[i], q.pos_y)
           + square_gap(store_z[i], q.pos_z);
         if (s > thr2) continue;
         if (src.size() >= HIT_LIMIT) begin
            ovf = 1;
            continue;
         end
         // round half up, never below one
         r = root_floor(s);
         if (s > r * r + r) r++;
         if (r == 0) r = 1;
         dp = 1;
         for (int k = 0; k < p; k++) dp = dp * r;
         src.push_back(i);
         raw.push_back((64'd1 << 47) / dp);
         coinc.push_back(s == 0);
         if (s == 0) ncoinc++;
         sum += (64'd1 << 47) / dp;
      end
      n = src.size();
      if (n == 0) begin
         o = '{row_id: q.vertex_id, source_id: '0, weight: '0,
               hit: 1'b0, overflow: 1'b0, last: 1'b1};
         expected_weights.push_back(o);
         return;
      end
      for (int i = 0; i < n; i++) begin
         if (ncoinc > 0)    w = coinc[i] ? 65535 / ncoinc : 0;
         else if (sum == 0) w = 65535 / n;
         else               w = raw[i] * 65535 / sum;
         o = '{row_id: q.vertex_id, source_id: src[i][SRC_W-1:0], weight: w[WGT_W-1:0],
               hit: 1'b1, overflow: ovf, last: (i == n - 1)};
         expected_weights.push_back(o);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type e, g;
      if (reset) begin
         stored    = 0;
         threshold = THRESHOLD_RESET;
         power     = POWER_RESET;
         expected_weights.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.data.index == CSR_THRESHOLD) threshold = csr_ch.data.data[THR_W-1:0];
            else if (csr_ch.data.index == CSR_POWER) power = csr_ch.data.data[POW_W-1:0];
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.data.cmd)
               CMD_CLEAR: stored = 0;
               CMD_APPEND: begin
                  if (stored < STORE_DEPTH) begin
                     store_x[stored] = req_ch.data.pos_x;
                     store_y[stored] = req_ch.data.pos_y;
                     store_z[stored] = req_ch.data.pos_z;
                     stored++;
                  end
               end
               CMD_QUERY: predict_row(req_ch.data);
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            g = rsp_ch.data;
            if (expected_weights.size() == 0) begin
               report_mismatch($sformatf("unexpected result row %0d src %0d",
                                         g.row_id, g.source_id));
            end else begin
               // take the oldest expected result
               e = expected_weights[0];
               expected_weights.delete(0);
               if (g.row_id !== e.row_id)
                  report_mismatch($sformatf("row_id %0d, want %0d", g.row_id, e.row_id));
               if (g.source_id !== e.source_id)
                  report_mismatch($sformatf("source_id %0d, want %0d",
                                            g.source_id, e.source_id));
               if (g.weight !== e.weight)
                  report_mismatch($sformatf("weight %0d, want %0d (src %0d)",
                                            g.weight, e.weight, e.source_id));
               if (g.hit !== e.hit)
                  report_mismatch($sformatf("hit %0b, want %0b", g.hit, e.hit));
               if (g.overflow !== e.overflow)
                  report_mismatch($sformatf("overflow %0b, want %0b", g.overflow, e.overflow));
               if (g.last !== e.last)
                  report_mismatch($sformatf("last %0b, want %0b", g.last, e.last));
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the inverse distance weights unit: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
   import idw_pkg::*;

   localparam int  CYCLE_LIMIT  = 2500000;
   localparam int  SETTLE_TICKS = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   idw_req_if req_ch ();
   idw_rsp_if rsp_ch ();
   idw_csr_if csr_ch ();

   int fail_count;
   int rows_pending;
   int cycles = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_left      = 0;
   logic hold_start   = 1'b0;

   // positions appended since the last clear, to aim queries at real sources
   logic signed [POS_W-1:0] placed_x [$], placed_y [$], placed_z [$];

   inverse_distance_weights_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   idw_checker chk (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_ch       (csr_ch),
      .fail_count   (fail_count),
      .rows_pending (rows_pending)
   );

   always #6 clock = ~clock;

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("inverse_distance_weights_unit: mismatch");
         $finish;
      end
   end

   // Count down a long receiver hold-off once the top asks for it.
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_start) hold_left <= 3000;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Receiver: stall at random, and all the time during a hold-off.
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Offer one item; valid stays up from item to item unless an idle gap is drawn.
   task automatic push_item(logic [1:0] cmd, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                            logic [VID_W-1:0] vid);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= '{cmd: cmd, pos_x: x, pos_y: y, pos_z: z, vertex_id: vid};
      do @(posedge clock); while (!req_ch.ready);
      if (cmd == CMD_CLEAR) begin
         placed_x.delete(); placed_y.delete(); placed_z.delete();
      end else if (cmd == CMD_APPEND) begin
         placed_x.push_back(x); placed_y.push_back(y); placed_z.push_back(z);
      end
   endtask

   // Drop valid, wait for every expected result, then let the block wind down.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= '{index: idx, data: value};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [POS_W-1:0] any_pos();
      return POS_W'($urandom_range(0, 24'hFFFFFF));
   endfunction

   function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] c, int span);
      return POS_W'(int'(c) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic signed [POS_W-1:0] any_center();
      return POS_W'(int'($urandom_range(0, 16000000)) - 8000000);
   endfunction

   function automatic logic [VID_W-1:0] any_vid();
      return VID_W'($urandom_range(0, 20'hFFFFF));
   endfunction

   initial begin
      int thr, pw, span, n, k, queries;
      logic signed [POS_W-1:0] cx, cy, cz;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero row sum, with far sources whose raw weight floors to zero.
      write_csr(CSR_THRESHOLD, 16'hFFFF);
      write_csr(CSR_POWER, 16'd3);
      push_item(CMD_CLEAR, 0, 0, 0, 0);
      push_item(CMD_APPEND, 60000, 0, 0, 0);
      push_item(CMD_APPEND, 0, 0, -60000, 0);
      push_item(CMD_QUERY, 0, 0, 0, 20'hFFFFF);
      // Coincident sources share the row; the far ones get zero.
      push_item(CMD_APPEND, 0, 0, 0, 0);
      push_item(CMD_APPEND, 0, 0, 0, 0);
      push_item(CMD_APPEND, 100, -200, 300, 0);
      push_item(CMD_QUERY, 0, 0, 0, 20'h00001);
      // Extreme corners: the opposite corner gives an empty row, the same corner a hit.
      push_item(CMD_APPEND, 24'sh800000, 24'sh800000, 24'sh800000, 20'hFFFFF);
      push_item(CMD_QUERY, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 20'h55555);
      push_item(CMD_QUERY, 24'sh800000, 24'sh800000, 24'sh800001, 20'hAAAAA);
      // Unused command is ignored.
      push_item(2'd3, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 20'hFFFFF);
      push_item(CMD_QUERY, 150, -100, 250, 20'h12345);
      settle();
      // Power zero acts as one; threshold zero keeps only coincident sources.
      write_csr(CSR_POWER, 16'hFFFC);
      write_csr(CSR_THRESHOLD, 16'd0);
      push_item(CMD_QUERY, 0, 0, 0, 20'h00002);
      push_item(CMD_QUERY, 1, 0, 0, 20'h00003);
      settle();
      write_csr(CSR_THRESHOLD, 16'd1000);
      write_csr(CSR_POWER, 16'd1);
      push_item(CMD_QUERY, 500, 0, 0, 20'h00004);
      settle();

      // Too many hits: 70 close sources, all in range.
      write_csr(CSR_POWER, 16'd2);
      push_item(CMD_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < 70; i++) push_item(CMD_APPEND, near(0, 400), near(0, 400), 0, 0);
      push_item(CMD_QUERY, 0, 0, 0, 20'h00077);
      settle();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         case (ph)
            0: thr = 65535;
            1: thr = 3000;
            2: thr = $urandom_range(1, 65535);
            default: thr = $urandom_range(0, 300);
         endcase
         pw = ph;
         write_csr(CSR_THRESHOLD, thr[15:0]);
         write_csr(CSR_POWER, {14'($urandom_range(0, 14'h3FFF)), pw[1:0]});
         span    = (thr / 2 > 0) ? thr / 2 : 1;
         queries = 0;
         // Hold results back for a long stretch while queries keep coming.
         if (ph == 0) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         while (queries < 4) begin
            cx = any_center(); cy = any_center(); cz = any_center();
            push_item(CMD_CLEAR, any_pos(), any_pos(), any_pos(), any_vid());
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
               push_item(CMD_APPEND, near(cx, span), near(cy, span), near(cz, span), any_vid());
            k = $urandom_range(2, 4);
            for (int j = 0; j < k; j++) begin
               case ($urandom_range(0, 9))
                  0: push_item(CMD_QUERY, any_pos(), any_pos(), any_pos(), any_vid());
                  1: push_item(2'd3, any_pos(), any_pos(), any_pos(), any_vid());
                  2, 3: begin
                     if (placed_x.size() > 0) begin
                        int s;
                        s = $urandom_range(0, placed_x.size() - 1);
                        push_item(CMD_QUERY, placed_x[s], placed_y[s], placed_z[s], any_vid());
                     end else begin
                        push_item(CMD_QUERY, cx, cy, cz, any_vid());
                     end
                  end
                  default:
                     push_item(CMD_QUERY, near(cx, span), near(cy, span), near(cz, span),
                               any_vid());
               endcase
               queries++;
            end
         end
         settle();
      end

      if (fail_count == 0 && rows_pending == 0) begin
         $display("inverse_distance_weights_unit: match");
      end else begin
         $display("inverse_distance_weights_unit: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/idw_pkg.sv
rtl/idw_if.sv
rtl/idw_div.sv
rtl/inverse_distance_weights_unit.sv
tb/sv/idw_checker.sv
tb/sv/tb.sv
